FILE: rtl/hrl_pkg.sv
package hrl_pkg;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_WRITE,
        MODE_READ
    } t_mode;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_BYTE    = 2'd2;
    localparam logic [1:0] OP_TIMEOUT = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ADDR_BAD  = 3'd1;
    localparam logic [2:0] ST_VALUE_BAD = 3'd2;
    localparam logic [2:0] ST_WSUM_BAD  = 3'd3;
    localparam logic [2:0] ST_RSUM_BAD  = 3'd4;
    localparam logic [2:0] ST_SHORT     = 3'd5;

    localparam logic [0:0] KIND_TX   = 1'b0;
    localparam logic [0:0] KIND_DONE = 1'b1;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_value;
    } t_result;

endpackage

FILE: rtl/hrl_check.sv
module hrl_check (
    input  hrl_pkg::t_mode    i_mode,
    input  logic [7:0]        i_addr,
    input  logic [7:0]        i_value,
    input  logic [5:0][7:0]   i_chars,
    output hrl_pkg::t_result  o_result
);

    function automatic logic [4:0] nib_of(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b0, c[3:0]};
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                r = {1'b0, 4'(c[3:0] + 4'd9)};
            end else begin
                r = 5'h10;
            end
            return r;
        end
    endfunction

    function automatic logic [7:0] pair_value(input logic [7:0] hi_c, input logic [7:0] lo_c);
        logic [4:0] hi;
        logic [4:0] lo;
        logic [7:0] r;
        begin
            hi = nib_of(hi_c);
            lo = nib_of(lo_c);
            if (lo[4]) begin
                r = 8'hFF;
            end else if (hi[4]) begin
                r = {4'hF, lo[3:0]};
            end else begin
                r = {hi[3:0], lo[3:0]};
            end
            return r;
        end
    endfunction

    logic [7:0] w_ea;
    logic [7:0] w_ev;
    logic [7:0] w_ec;
    logic       w_sum_ok;

    assign w_ea     = pair_value(i_chars[0], i_chars[1]);
    assign w_ev     = pair_value(i_chars[2], i_chars[3]);
    assign w_ec     = pair_value(i_chars[4], i_chars[5]);
    assign w_sum_ok = (w_ec == 8'(w_ea + w_ev));

    always_comb begin
        o_result.status     = hrl_pkg::ST_OK;
        o_result.read_value = 8'd0;
        if (i_mode == hrl_pkg::MODE_WRITE) begin
            if (i_addr == 8'd0 && i_value == 8'd0) begin
                o_result.status = hrl_pkg::ST_OK;
            end else if (w_ea != i_addr) begin
                o_result.status = hrl_pkg::ST_ADDR_BAD;
            end else if (w_ev != i_value) begin
                o_result.status = hrl_pkg::ST_VALUE_BAD;
            end else if (!w_sum_ok) begin
                o_result.status = hrl_pkg::ST_WSUM_BAD;
            end
        end else begin
            if (w_ea != i_addr) begin
                o_result.status = hrl_pkg::ST_ADDR_BAD;
            end else if (!w_sum_ok) begin
                o_result.status = hrl_pkg::ST_RSUM_BAD;
            end else begin
                o_result.read_value = w_ev;
            end
        end
    end

endmodule

FILE: rtl/hex_register_link_master_unit.sv
// Host side of an ASCII-hex register link. Each accepted input word is decoded in the
// cycle it is taken and its results are loaded into a ten-entry output shift buffer that
// drains one word per cycle while the output is not stalled: a write command yields ten
// transmit words, a read command eight, the eighth reply byte or a timeout during a
// pending command one completion word, and other inputs none. The first result appears
// the cycle after acceptance. New input is held off while the buffer still drains a
// command. The next input word is taken in the same cycle the final buffered result is
// taken, so there is no gap between runs.
module hex_register_link_master_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_reg_address,
    input  logic [7:0] i_write_value,
    input  logic [7:0] i_received_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [7:0] o_transmit_byte,
    output logic [2:0] o_status,
    output logic [7:0] o_read_value,
    output logic       o_last
);

    localparam int FRAME_LEN = 10;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        begin
            if (n < 4'd10) begin
                r = 8'h30 + {4'd0, n};
            end else begin
                r = 8'h57 + {4'd0, n};
            end
            return r;
        end
    endfunction

    hrl_pkg::t_mode      r_mode, n_mode;
    logic [7:0]          r_addr, n_addr;
    logic [7:0]          r_value, n_value;
    logic [2:0]          r_count, n_count;
    logic [5:0][7:0]     r_chars, n_chars;
    logic [7:0]          r_buf [FRAME_LEN];
    logic [7:0]          n_buf [FRAME_LEN];
    logic [3:0]          r_cnt, n_cnt;
    logic                r_kind, n_kind;
    logic [2:0]          r_status, n_status;
    logic [7:0]          r_rdval, n_rdval;

    logic                w_accept;
    logic                w_take;
    logic [7:0]          w_sum;
    logic [7:0]          w_prev;
    hrl_pkg::t_result    w_result;

    hrl_check u_check (
        .i_mode   (r_mode),
        .i_addr   (r_addr),
        .i_value  (r_value),
        .i_chars  (r_chars),
        .o_result (w_result)
    );

    assign o_valid         = (r_cnt != 4'd0);
    assign o_stall         = (r_cnt > 4'd1) || (r_cnt == 4'd1 && i_stall);
    assign w_accept        = i_valid && !o_stall;
    assign w_take          = o_valid && !i_stall;
    assign w_sum           = 8'(i_reg_address + i_write_value);
    assign w_prev          = 8'(i_reg_address - 8'd1);

    assign o_kind          = r_kind;
    assign o_transmit_byte = r_buf[0];
    assign o_status        = r_status;
    assign o_read_value    = r_rdval;
    assign o_last          = (r_cnt == 4'd1);

    always_comb begin
        n_mode   = r_mode;
        n_addr   = r_addr;
        n_value  = r_value;
        n_count  = r_count;
        n_chars  = r_chars;
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_kind   = r_kind;
        n_status = r_status;
        n_rdval  = r_rdval;

        // advance the output buffer
        if (w_take) begin
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                n_buf[i] = r_buf[i + 1];
            end
            n_cnt = r_cnt - 4'd1;
        end

        if (w_accept) begin
            case (i_opcode)
                hrl_pkg::OP_WRITE: begin
                    n_mode   = hrl_pkg::MODE_WRITE;
                    n_addr   = i_reg_address;
                    n_value  = i_write_value;
                    n_count  = 3'd0;
                    n_buf[0] = 8'h7B;
                    n_buf[1] = 8'h30;
                    n_buf[2] = 8'h30;
                    n_buf[3] = hex_digit(i_reg_address[7:4]);
                    n_buf[4] = hex_digit(i_reg_address[3:0]);
                    n_buf[5] = hex_digit(i_write_value[7:4]);
                    n_buf[6] = hex_digit(i_write_value[3:0]);
                    n_buf[7] = hex_digit(w_sum[7:4]);
                    n_buf[8] = hex_digit(w_sum[3:0]);
                    n_buf[9] = 8'h7D;
                    n_cnt    = 4'd10;
                    n_kind   = hrl_pkg::KIND_TX;
                    n_status = hrl_pkg::ST_OK;
                    n_rdval  = 8'd0;
                end
                hrl_pkg::OP_READ: begin
                    n_mode   = hrl_pkg::MODE_READ;
                    n_addr   = i_reg_address;
                    n_value  = 8'd0;
                    n_count  = 3'd0;
                    n_buf[0] = 8'h7B;
                    n_buf[1] = 8'h66;
                    n_buf[2] = 8'h66;
                    n_buf[3] = hex_digit(i_reg_address[7:4]);
                    n_buf[4] = hex_digit(i_reg_address[3:0]);
                    n_buf[5] = hex_digit(w_prev[7:4]);
                    n_buf[6] = hex_digit(w_prev[3:0]);
                    n_buf[7] = 8'h7D;
                    n_cnt    = 4'd8;
                    n_kind   = hrl_pkg::KIND_TX;
                    n_status = hrl_pkg::ST_OK;
                    n_rdval  = 8'd0;
                end
                hrl_pkg::OP_TIMEOUT: begin
                    if (r_mode != hrl_pkg::MODE_NONE) begin
                        n_mode   = hrl_pkg::MODE_NONE;
                        n_count  = 3'd0;
                        n_buf[0] = 8'd0;
                        n_cnt    = 4'd1;
                        n_kind   = hrl_pkg::KIND_DONE;
                        n_status = hrl_pkg::ST_SHORT;
                        n_rdval  = 8'd0;
                    end
                end
                hrl_pkg::OP_BYTE: begin
                    if (r_mode != hrl_pkg::MODE_NONE) begin
                        if (r_count == 3'd7) begin
                            n_mode   = hrl_pkg::MODE_NONE;
                            n_count  = 3'd0;
                            n_buf[0] = 8'd0;
                            n_cnt    = 4'd1;
                            n_kind   = hrl_pkg::KIND_DONE;
                            n_status = w_result.status;
                            n_rdval  = w_result.read_value;
                        end else begin
                            for (int i = 0; i < 6; i++) begin
                                if (r_count == 3'(i + 1)) begin
                                    n_chars[i] = i_received_byte;
                                end
                            end
                            n_count = r_count + 3'd1;
                        end
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= hrl_pkg::MODE_NONE;
            r_addr  <= 8'd0;
            r_value <= 8'd0;
            r_count <= 3'd0;
            r_cnt   <= 4'd0;
        end else begin
            r_mode  <= n_mode;
            r_addr  <= n_addr;
            r_value <= n_value;
            r_count <= n_count;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chars  <= n_chars;
        r_buf    <= n_buf;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_rdval  <= n_rdval;
    end

endmodule

FILE: rtl/hrl_checker.sv
module hrl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_kind,
    input logic [7:0] o_transmit_byte,
    input logic [2:0] o_status,
    input logic [7:0] o_read_value,
    input logic       o_last
);

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> o_last)
        else $error("completion word not marked last");

    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> (o_status == hrl_pkg::ST_OK && o_read_value == 8'd0))
        else $error("transmit word carries status or value");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_stall)
        else $error("input taken while a run is still draining");

    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (o_status <= hrl_pkg::ST_SHORT &&
                                 (o_read_value == 8'd0 || o_status == hrl_pkg::ST_OK)))
        else $error("bad completion status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_transmit_byte) && $stable(o_kind)))
        else $error("stalled output word changed");

endmodule

bind hex_register_link_master_unit hrl_checker u_hrl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_kind          (o_kind),
    .o_transmit_byte (o_transmit_byte),
    .o_status        (o_status),
    .o_read_value    (o_read_value),
    .o_last          (o_last)
);
